FILE: rtl/core/vgc_pkg.sv
package vgc_pkg;

  localparam int MAX_VERTS = 4096;
  localparam int MAX_CELLS = 4096;
  localparam int MAX_GRID  = 1024;
  localparam int COORD_W   = 16;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int AXIS_W    = 10;
  localparam int KEY_W     = 3 * AXIS_W;
  localparam int SUM_W     = 29;
  localparam int INV_W     = 26;
  localparam int GRID_W    = 11;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] CMD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_TRI    = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] KIND_TRI   = 2'd0;
  localparam logic [1:0] KIND_CEN   = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_RANGE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_GRID  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INV_Z = 3'd6;

  typedef struct packed {
    logic [1:0]              cmd;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [IDX_W-1:0]        corner_a;
    logic [IDX_W-1:0]        corner_b;
    logic [IDX_W-1:0]        corner_c;
    logic [IDX_W-1:0]        cell_number;
  } in_t;

  typedef struct packed {
    logic [1:0]              kind;
    logic [IDX_W-1:0]        new_a;
    logic [IDX_W-1:0]        new_b;
    logic [IDX_W-1:0]        new_c;
    logic signed [COORD_W-1:0] cen_x;
    logic signed [COORD_W-1:0] cen_y;
    logic signed [COORD_W-1:0] cen_z;
    logic [CNT_W-1:0]        cells_used;
    logic [1:0]              error_code;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
  } cell_t;

endpackage

FILE: rtl/core/vertex_grid_clustering.sv
// Vertex clustering for mesh simplification.
// Input words arrive on in_data with in_valid; a word is taken when in_valid is
// high and in_stall is low. Commands: vertex, triangle, centroid read, clear.
// Results leave on out_data with out_valid and are held while out_stall is high.
// The block takes one word at a time and stalls its input until that word is
// finished. A finished result sits in the output register, so the next word is
// accepted while it waits; the block only blocks if a second result is ready
// before the first has gone.
// A vertex is mapped to a grid cell (one shared multiplier, used for each
// axis in turn), the stored cell keys are searched in a linear key scan, and
// the matching cell is updated or a new cell is added to the store.
// A triangle takes three reads of the remap memory; a read uses one shared
// serial divider for each axis in turn; a clear resets the vertex and cell
// counts. Configuration is written through cfg_we, cfg_index and cfg_data;
// the user must write it only while idle, which the block does not enforce.
// Reset (rst_n low at a clock edge) empties the vertex and cell stores and
// restores the register defaults; no clearing pass is needed.
module vertex_grid_clustering (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  vgc_pkg::in_t                     in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output vgc_pkg::out_t                    out_data,
  input  logic                             cfg_we,
  input  logic [vgc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vgc_pkg::INV_W-1:0]        cfg_data
);
  import vgc_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MAP    = 4'd1;
  localparam logic [3:0] S_SCAN_A = 4'd2;
  localparam logic [3:0] S_SCAN_B = 4'd3;
  localparam logic [3:0] S_MISS   = 4'd4;
  localparam logic [3:0] S_UPD_A  = 4'd5;
  localparam logic [3:0] S_UPD_B  = 4'd6;
  localparam logic [3:0] S_TRI    = 4'd7;
  localparam logic [3:0] S_TRI_C  = 4'd8;
  localparam logic [3:0] S_RD_A   = 4'd9;
  localparam logic [3:0] S_RD_B   = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_POST   = 4'd12;

  logic [GRID_W-1:0] grid_r;
  logic signed [COORD_W-1:0] min_r [3];
  logic [INV_W-1:0]  inv_r [3];

  logic [3:0]        state_r, state_nxt;
  in_t               item_r;
  logic [CNT_W-1:0]  vseen_r, vseen_nxt, ctotal_r, ctotal_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  found_r, found_nxt;
  logic [KEY_W-1:0]  key_r;
  logic [1:0]        t_r, t_nxt;
  logic [IDX_W-1:0]  rc_r [3];
  logic [1:0]        dax_r, dax_nxt;
  logic              div_go_r, div_go_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              res_r, res_nxt, out_r;
  cell_t             cell_r;
  logic signed [COORD_W-1:0] cen_r [3];

  logic [KEY_W-1:0]  key_mem [MAX_CELLS];
  cell_t             cell_mem [MAX_CELLS];
  logic [IDX_W-1:0]  remap_mem [MAX_VERTS];
  logic [KEY_W-1:0]  key_q;
  cell_t             cell_q;
  logic [IDX_W-1:0]  remap_q;

  logic [IDX_W-1:0]  cell_addr, remap_addr;
  logic              key_we, cell_we, remap_we;
  cell_t             cell_wd;

  logic signed [COORD_W-1:0] pos [3];
  logic              map_start, map_done;
  logic [KEY_W-1:0]  map_key;
  logic              accept;
  logic signed [SUM_W-1:0] div_num;
  logic              div_done;
  logic signed [COORD_W-1:0] div_q;
  logic [IDX_W-1:0]  corner;

  assign pos[0] = in_data.pos_x;
  assign pos[1] = in_data.pos_y;
  assign pos[2] = in_data.pos_z;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign map_start = accept && (in_data.cmd == CMD_VERTEX) &&
                     (vseen_r < CNT_W'(MAX_VERTS));

  vgc_cell_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (map_start),
    .pos       (pos),
    .mins      (min_r),
    .invs      (inv_r),
    .grid_size (grid_r),
    .done      (map_done),
    .key       (map_key)
  );

  always_comb begin
    case (dax_r)
      2'd0:    div_num = cell_r.sx;
      2'd1:    div_num = cell_r.sy;
      default: div_num = cell_r.sz;
    endcase
  end

  vgc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (div_num),
    .divisor  (cell_r.cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= GRID_W'(1);
      for (int i = 0; i < 3; i++) begin
        min_r[i] <= '0;
        inv_r[i] <= INV_W'(65536);
      end
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID:  grid_r   <= cfg_data[GRID_W-1:0];
        REG_MIN_X: min_r[0] <= cfg_data[COORD_W-1:0];
        REG_MIN_Y: min_r[1] <= cfg_data[COORD_W-1:0];
        REG_MIN_Z: min_r[2] <= cfg_data[COORD_W-1:0];
        REG_INV_X: inv_r[0] <= cfg_data;
        REG_INV_Y: inv_r[1] <= cfg_data;
        REG_INV_Z: inv_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (t_r)
      2'd0:    corner = item_r.corner_a;
      2'd1:    corner = item_r.corner_b;
      default: corner = item_r.corner_c;
    endcase
    remap_addr = (state_r == S_TRI) ? corner : vseen_r[IDX_W-1:0];
    if (state_r == S_RD_A) begin
      cell_addr = item_r.cell_number;
    end else if (state_r == S_MISS) begin
      cell_addr = ctotal_r[IDX_W-1:0];
    end else begin
      cell_addr = found_r;
    end
    key_we   = 1'b0;
    cell_we  = 1'b0;
    remap_we = 1'b0;
    cell_wd.cnt = cell_q.cnt + 1'b1;
    cell_wd.sx  = cell_q.sx + SUM_W'(item_r.pos_x);
    cell_wd.sy  = cell_q.sy + SUM_W'(item_r.pos_y);
    cell_wd.sz  = cell_q.sz + SUM_W'(item_r.pos_z);
    if (state_r == S_MISS) begin
      cell_wd.cnt = CNT_W'(1);
      cell_wd.sx  = SUM_W'(item_r.pos_x);
      cell_wd.sy  = SUM_W'(item_r.pos_y);
      cell_wd.sz  = SUM_W'(item_r.pos_z);
    end

    state_nxt     = state_r;
    vseen_nxt     = vseen_r;
    ctotal_nxt    = ctotal_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    t_nxt         = t_r;
    dax_nxt       = dax_r;
    div_go_nxt    = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          // The cell count cannot change between here and the result word.
          res_nxt.cells_used = ctotal_r;
          case (in_data.cmd)
            CMD_VERTEX: begin
              if (vseen_r >= CNT_W'(MAX_VERTS)) begin
                res_nxt.kind       = KIND_ERR;
                res_nxt.error_code = ERR_FULL;
                state_nxt          = S_POST;
              end else begin
                state_nxt = S_MAP;
              end
            end
            CMD_TRI: begin
              if ({1'b0, in_data.corner_a} >= vseen_r ||
                  {1'b0, in_data.corner_b} >= vseen_r ||
                  {1'b0, in_data.corner_c} >= vseen_r) begin
                res_nxt.kind       = KIND_ERR;
                res_nxt.error_code = ERR_RANGE;
                state_nxt          = S_POST;
              end else begin
                t_nxt     = 2'd0;
                state_nxt = S_TRI;
              end
            end
            CMD_READ: begin
              if ({1'b0, in_data.cell_number} >= ctotal_r) begin
                res_nxt.kind       = KIND_ERR;
                res_nxt.error_code = ERR_RANGE;
                state_nxt          = S_POST;
              end else begin
                state_nxt = S_RD_A;
              end
            end
            default: begin
              vseen_nxt  = '0;
              ctotal_nxt = '0;
            end
          endcase
        end
      end
      S_MAP: begin
        if (map_done) begin
          scan_nxt  = '0;
          state_nxt = (ctotal_r == '0) ? S_MISS : S_SCAN_A;
        end
      end
      S_SCAN_A: state_nxt = S_SCAN_B;
      S_SCAN_B: begin
        if (key_q == key_r) begin
          found_nxt = scan_r[IDX_W-1:0];
          state_nxt = S_UPD_A;
        end else if (scan_r + 1'b1 == ctotal_r) begin
          state_nxt = S_MISS;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          state_nxt = S_SCAN_A;
        end
      end
      S_MISS: begin
        if (ctotal_r >= CNT_W'(MAX_CELLS)) begin
          res_nxt.kind       = KIND_ERR;
          res_nxt.error_code = ERR_FULL;
          state_nxt          = S_POST;
        end else begin
          key_we     = 1'b1;
          cell_we    = 1'b1;
          remap_we   = 1'b1;
          found_nxt  = ctotal_r[IDX_W-1:0];
          ctotal_nxt = ctotal_r + 1'b1;
          vseen_nxt  = vseen_r + 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_UPD_A: state_nxt = S_UPD_B;
      S_UPD_B: begin
        cell_we   = 1'b1;
        remap_we  = 1'b1;
        vseen_nxt = vseen_r + 1'b1;
        state_nxt = S_IDLE;
      end
      S_TRI: begin
        t_nxt = t_r + 2'd1;
        if (t_r == 2'd2) begin
          state_nxt = S_TRI_C;
        end
      end
      S_TRI_C: begin
        if (rc_r[0] == rc_r[1] || rc_r[1] == remap_q || rc_r[0] == remap_q) begin
          state_nxt = S_IDLE;
        end else begin
          res_nxt.kind  = KIND_TRI;
          res_nxt.new_a = rc_r[0];
          res_nxt.new_b = rc_r[1];
          res_nxt.new_c = remap_q;
          state_nxt     = S_POST;
        end
      end
      S_RD_A: state_nxt = S_RD_B;
      S_RD_B: begin
        dax_nxt    = 2'd0;
        div_go_nxt = 1'b1;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (dax_r == 2'd2) begin
            res_nxt.kind  = KIND_CEN;
            res_nxt.cen_x = cen_r[0];
            res_nxt.cen_y = cen_r[1];
            res_nxt.cen_z = div_q;
            state_nxt     = S_POST;
          end else begin
            dax_nxt    = dax_r + 2'd1;
            div_go_nxt = 1'b1;
          end
        end
      end
      S_POST: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vseen_r     <= '0;
      ctotal_r    <= '0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vseen_r     <= vseen_nxt;
      ctotal_r    <= ctotal_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= div_go_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_data;
    end
    if (state_r == S_MAP && map_done) begin
      key_r <= map_key;
    end
    scan_r  <= scan_nxt;
    found_r <= found_nxt;
    t_r     <= t_nxt;
    dax_r   <= dax_nxt;
    res_r   <= res_nxt;
    if (state_r == S_TRI && t_r != 2'd0) begin
      rc_r[t_r - 2'd1] <= remap_q;
    end
    if (state_r == S_RD_B) begin
      cell_r <= cell_q;
    end
    if (state_r == S_DIV && div_done && dax_r != 2'd2) begin
      cen_r[dax_r] <= div_q;
    end
    if (state_r == S_POST && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
  end

  // Stores: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[ctotal_r[IDX_W-1:0]] <= key_r;
    end
    key_q <= key_mem[scan_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wd;
    end
    cell_q <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (remap_we) begin
      remap_mem[vseen_r[IDX_W-1:0]] <= (state_r == S_MISS) ? ctotal_r[IDX_W-1:0] : found_r;
    end
    remap_q <= remap_mem[remap_addr];
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/core/vgc_cell_map.sv
module vgc_cell_map (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [vgc_pkg::COORD_W-1:0] pos [3],
  input  logic signed [vgc_pkg::COORD_W-1:0] mins [3],
  input  logic [vgc_pkg::INV_W-1:0]       invs [3],
  input  logic [vgc_pkg::GRID_W-1:0]      grid_size,
  output logic                            done,
  output logic [vgc_pkg::KEY_W-1:0]       key
);
  import vgc_pkg::*;

  logic signed [COORD_W:0] d_r [3];
  logic [INV_W-1:0]        inv_r [3];
  logic [AXIS_W-1:0]       nm1_r, nm1;
  logic [1:0]              ax_r, ax_nxt;
  logic                    busy_r, busy_nxt, ph_r, ph_nxt, done_r, done_nxt;
  logic signed [COORD_W+INV_W+1:0] prod_r;
  logic signed [INV_W:0]   iv;
  logic [COORD_W+INV_W-16:0] q;
  logic [AXIS_W-1:0]       cell_idx;
  logic [KEY_W-1:0]        key_r;

  always_comb begin
    if (grid_size == '0) begin
      nm1 = '0;
    end else if (grid_size > GRID_W'(MAX_GRID)) begin
      nm1 = AXIS_W'(MAX_GRID - 1);
    end else begin
      nm1 = AXIS_W'(grid_size - 1'b1);
    end
    iv = signed'({1'b0, inv_r[ax_r]});
    q  = prod_r[COORD_W+INV_W:16];
    if (prod_r[COORD_W+INV_W+1]) begin
      cell_idx = '0;
    end else if (q > {{(COORD_W+INV_W-15-AXIS_W){1'b0}}, nm1_r}) begin
      cell_idx = nm1_r;
    end else begin
      cell_idx = q[AXIS_W-1:0];
    end
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    ax_nxt   = ax_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      ph_nxt   = 1'b0;
      ax_nxt   = 2'd0;
    end else if (busy_r) begin
      ph_nxt = ~ph_r;
      if (ph_r) begin
        if (ax_r == 2'd2) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 1'b0;
      ax_r   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
      ax_r   <= ax_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 3; i++) begin
        d_r[i]   <= (COORD_W+1)'(pos[i]) - (COORD_W+1)'(mins[i]);
        inv_r[i] <= invs[i];
      end
      nm1_r <= nm1;
    end
    if (busy_r && !ph_r) begin
      prod_r <= d_r[ax_r] * iv;
    end
    if (busy_r && ph_r) begin
      key_r <= {key_r[KEY_W-AXIS_W-1:0], cell_idx};
    end
  end

  assign done = done_r;
  assign key  = key_r;

endmodule

FILE: rtl/core/vgc_div.sv
module vgc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [vgc_pkg::SUM_W-1:0]  dividend,
  input  logic [vgc_pkg::CNT_W-1:0]         divisor,
  output logic                              done,
  output logic signed [vgc_pkg::COORD_W-1:0] quotient
);
  import vgc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0]  q_r;
  logic [CNT_W-1:0]  rem_r, dv_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt, done_r, done_nxt, neg_r;
  logic [CNT_W:0]    trial;
  logic              ge;
  logic [SUM_W-1:0]  qs;

  always_comb begin
    trial = {rem_r, q_r[SUM_W-1]};
    ge    = trial >= {1'b0, dv_r};
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
    qs = neg_r ? (~q_r + 1'b1) : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      q_r   <= dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_r <= '0;
      dv_r  <= (divisor == '0) ? CNT_W'(1) : divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[SUM_W-2:0], ge};
      rem_r <= ge ? CNT_W'(trial - {1'b0, dv_r}) : trial[CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = qs[COORD_W-1:0];

endmodule
